// File: hw/rtl/edf_pkg.sv
// Shared types, widths and constants of the echo distance filter.
package edf_pkg;

    localparam int AVG_DEPTH_DEF   = 4;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int ECHO_W     = 15;
    localparam int TIME_W     = 32;
    localparam int DIST_W     = 12;
    localparam int RATE_W     = 16;
    localparam int LIMIT_W    = 12;
    localparam int INTERVAL_W = 16;
    localparam int COUNT_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 32;

    localparam int DIST_MAX   = 4095;
    localparam int DIST_RESET = 1200;

    // Echo width to millimetres: width * 343 / 2000, with the division done as a shift
    // by 4 followed by a reciprocal multiply for the remaining factor of 125.
    localparam int PROD_DIST_W  = 24;
    localparam logic [8:0] SOUND_MUL = 9'd343;
    localparam int DIST_DIVISOR = 2000;
    localparam int PRE_SHIFT    = 4;
    localparam int POST_DIV     = DIST_DIVISOR >> PRE_SHIFT;
    localparam int DIV_SHIFT    = 27;
    localparam int DIV_MUL_W    = 21;
    localparam longint DIV_MUL_L = ((longint'(1) << DIV_SHIFT) + POST_DIV - 1) / POST_DIV;
    localparam logic [DIV_MUL_W-1:0] DIV_MUL = DIV_MUL_W'(DIV_MUL_L);
    localparam int QUOT_PROD_W  = (PROD_DIST_W - PRE_SHIFT) + DIV_MUL_W;
    localparam int QUOT_W       = QUOT_PROD_W - DIV_SHIFT;

    // Rate arithmetic.
    localparam int DW_W      = 16;
    localparam int USEC_W    = 20;
    localparam logic [USEC_W-1:0] USEC_SCALE = 20'd1000000;
    localparam int PROD_W    = 35;
    localparam int DVD_W     = 38;
    localparam int DVS_W     = 32;
    localparam int SMOOTH_W  = 36;
    localparam int SUM4_W    = 39;

    // The smoothing divide by five runs over two digits of half the dividend width.
    // Each digit, with the remainder of the digit before it on top, is divided by a
    // reciprocal multiply that is exact for every value of that width.
    localparam int SMOOTH_DIV  = 5;
    localparam int AVG_DIG_W   = DVD_W / 2;
    localparam int AVG_REM_W   = 3;
    localparam int AVG_V_W     = AVG_REM_W + AVG_DIG_W;
    localparam int AVG_SHIFT   = AVG_V_W + 2;
    localparam int AVG_PROD_W  = 2 * AVG_V_W;
    localparam longint AVG_MUL_L = ((longint'(1) << AVG_SHIFT) + SMOOTH_DIV - 1) / SMOOTH_DIV;
    localparam logic [AVG_V_W-1:0] AVG_MUL = AVG_V_W'(AVG_MUL_L);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ECHO_MIN     = 3'd0,
        CFG_ECHO_MAX     = 3'd1,
        CFG_NEAR_LIMIT   = 3'd2,
        CFG_MIN_INTERVAL = 3'd3,
        CFG_NEAR_NEEDED  = 3'd4
    } edf_cfg_idx_t;

    typedef struct packed {
        logic [ECHO_W-1:0]     echo_min_us;
        logic [ECHO_W-1:0]     echo_max_us;
        logic [LIMIT_W-1:0]    near_limit_mm;
        logic [INTERVAL_W-1:0] min_interval_ms;
        logic [COUNT_W-1:0]    near_count_needed;
    } edf_cfg_t;

    localparam edf_cfg_t CFG_RST = '{
        echo_min_us:       15'd115,
        echo_max_us:       15'd23500,
        near_limit_mm:     12'd200,
        min_interval_ms:   16'd20,
        near_count_needed: 8'd3
    };

    // One classified measurement handed from the front end to the rate back end.
    typedef struct packed {
        logic [DIST_W-1:0]      mean;
        logic                   emergency;
        logic                   upd;
        logic signed [DW_W-1:0] dw;
        logic [TIME_W-1:0]      dt;
    } edf_job_t;

endpackage

// File: hw/rtl/edf_divider.sv
// Restoring serial divider, one quotient bit per cycle.
module edf_divider (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [edf_pkg::DVD_W-1:0]  dividend,
    input  logic [edf_pkg::DVS_W-1:0]  divisor,
    output logic                       done,
    output logic [edf_pkg::DVD_W-1:0]  quotient
);
    import edf_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;

    logic [DVS_W:0]   rem_shift;
    logic [DVS_W:0]   rem_sub;
    logic             fits;

    assign rem_shift = {rem_reg, quo_reg[DVD_W-1]};
    assign fits      = rem_shift >= {1'b0, dvs_reg};
    assign rem_sub   = rem_shift - {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DVD_W);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            quo_next = {quo_reg[DVD_W-2:0], fits};
            rem_next = fits ? rem_sub[DVS_W-1:0] : rem_shift[DVS_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: hw/rtl/edf_queue.sv
// Small register queue of classified measurements between front and back end.
module edf_queue #(
    parameter int DEPTH = edf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  edf_pkg::edf_job_t in_job,
    output logic              out_valid,
    input  logic              out_ready,
    output edf_pkg::edf_job_t out_job
);
    import edf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    edf_job_t         slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign in_ready  = count_reg != CNT_W'(DEPTH);
    assign out_valid = count_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_job   = slots_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= in_job;
        end
    end

endmodule

// File: hw/rtl/edf_front.sv
// Front end: accepts measurements, converts and averages distance, counts near readings.
module edf_front #(
    parameter int AVG_DEPTH = edf_pkg::AVG_DEPTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  edf_pkg::edf_cfg_t           cfg,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        in_echo_valid,
    input  logic [edf_pkg::ECHO_W-1:0]  in_echo_us,
    input  logic [edf_pkg::TIME_W-1:0]  in_time_ms,
    output logic                        job_valid,
    input  logic                        job_ready,
    output edf_pkg::edf_job_t           job
);
    import edf_pkg::*;

    localparam int POS_W      = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int SUM_W      = $clog2(AVG_DEPTH * DIST_MAX + 1);
    localparam int MEAN_SHIFT = SUM_W + $clog2(AVG_DEPTH);
    localparam int RECIP_W    = SUM_W + 1;
    localparam int MPROD_W    = SUM_W + RECIP_W;
    localparam longint RECIP_L = ((longint'(1) << MEAN_SHIFT) + AVG_DEPTH - 1) / AVG_DEPTH;
    localparam logic [RECIP_W-1:0] RECIP    = RECIP_W'(RECIP_L);
    localparam logic [SUM_W-1:0]   SUM_RST  = SUM_W'(AVG_DEPTH * DIST_RESET);
    localparam logic [POS_W-1:0]   POS_LAST = POS_W'(AVG_DEPTH - 1);

    typedef enum logic [2:0] {
        F_IDLE,
        F_DIST,
        F_RING,
        F_MEAN,
        F_PUSH
    } state_t;

    state_t                  state_reg, state_next;
    logic [DIST_W-1:0]       ring_reg [AVG_DEPTH];
    logic [DIST_W-1:0]       ring_next [AVG_DEPTH];
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic [SUM_W-1:0]        sum_reg, sum_next;
    logic [TIME_W-1:0]       last_time_reg, last_time_next;
    logic [ECHO_W-1:0]       last_width_reg, last_width_next;
    logic [COUNT_W-1:0]      near_count_reg, near_count_next;

    logic [PROD_DIST_W-1:0]  prod_reg, prod_next;
    logic                    in_win_reg, in_win_next;
    logic [DIST_W-1:0]       dist_reg, dist_next;
    logic [DIST_W-1:0]       mean_reg, mean_next;
    logic                    upd_reg, upd_next;
    logic signed [DW_W-1:0]  dw_reg, dw_next;
    logic [TIME_W-1:0]       dt_reg, dt_next;

    logic [ECHO_W-1:0]       width_in;
    logic [TIME_W-1:0]       dt_in;
    logic [QUOT_PROD_W-1:0]  quot_prod;
    logic [QUOT_W-1:0]       quot;
    logic [DIST_W-1:0]       dist_sat;
    logic [MPROD_W-1:0]      mean_prod;
    logic                    is_near;
    logic [COUNT_W-1:0]      near_calc;

    assign width_in  = in_echo_valid ? in_echo_us : '0;
    assign dt_in     = in_time_ms - last_time_reg;
    assign quot_prod = QUOT_PROD_W'(prod_reg[PROD_DIST_W-1:PRE_SHIFT]) * QUOT_PROD_W'(DIV_MUL);
    assign quot      = quot_prod[QUOT_PROD_W-1:DIV_SHIFT];
    assign dist_sat  = (quot > QUOT_W'(DIST_MAX)) ? DIST_W'(DIST_MAX) : quot[DIST_W-1:0];
    assign mean_prod = MPROD_W'(sum_reg) * MPROD_W'(RECIP);

    // A reading is near when the averaged distance is nonzero and under the limit;
    // the count stops once it has reached the needed number.
    assign is_near = (mean_reg != '0) && (mean_reg < cfg.near_limit_mm);
    always_comb begin
        if (!is_near) begin
            near_calc = '0;
        end else if (near_count_reg < cfg.near_count_needed) begin
            near_calc = near_count_reg + 1'b1;
        end else begin
            near_calc = near_count_reg;
        end
    end

    assign in_ready      = state_reg == F_IDLE;
    assign job_valid     = state_reg == F_PUSH;
    assign job.mean      = mean_reg;
    assign job.emergency = near_calc >= cfg.near_count_needed;
    assign job.upd       = upd_reg;
    assign job.dw        = dw_reg;
    assign job.dt        = dt_reg;

    always_comb begin
        state_next      = state_reg;
        ring_next       = ring_reg;
        pos_next        = pos_reg;
        sum_next        = sum_reg;
        last_time_next  = last_time_reg;
        last_width_next = last_width_reg;
        near_count_next = near_count_reg;
        prod_next       = prod_reg;
        in_win_next     = in_win_reg;
        dist_next       = dist_reg;
        mean_next       = mean_reg;
        upd_next        = upd_reg;
        dw_next         = dw_reg;
        dt_next         = dt_reg;
        case (state_reg)
            F_IDLE: begin
                if (in_valid) begin
                    prod_next   = PROD_DIST_W'(in_echo_us) * PROD_DIST_W'(SOUND_MUL);
                    in_win_next = in_echo_valid && (in_echo_us > cfg.echo_min_us)
                                  && (in_echo_us < cfg.echo_max_us);
                    // A zero stored stamp, a stamp that did not advance, or too short
                    // an interval leaves the rate as it is.
                    upd_next    = (last_time_reg != '0) && (in_time_ms > last_time_reg)
                                  && (dt_in > TIME_W'(cfg.min_interval_ms));
                    dt_next     = dt_in;
                    dw_next     = $signed({1'b0, width_in}) - $signed({1'b0, last_width_reg});
                    last_time_next  = in_time_ms;
                    last_width_next = width_in;
                    state_next  = F_DIST;
                end
            end
            F_DIST: begin
                dist_next  = in_win_reg ? dist_sat : '0;
                state_next = F_RING;
            end
            F_RING: begin
                ring_next[pos_reg] = dist_reg;
                sum_next   = sum_reg - SUM_W'(ring_reg[pos_reg]) + SUM_W'(dist_reg);
                pos_next   = (pos_reg == POS_LAST) ? '0 : pos_reg + 1'b1;
                state_next = F_MEAN;
            end
            F_MEAN: begin
                mean_next  = mean_prod[MEAN_SHIFT +: DIST_W];
                state_next = F_PUSH;
            end
            F_PUSH: begin
                if (job_ready) begin
                    near_count_next = near_calc;
                    state_next      = F_IDLE;
                end
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= F_IDLE;
            for (int i = 0; i < AVG_DEPTH; i++) begin
                ring_reg[i] <= DIST_W'(DIST_RESET);
            end
            pos_reg        <= '0;
            sum_reg        <= SUM_RST;
            last_time_reg  <= '0;
            last_width_reg <= '0;
            near_count_reg <= '0;
        end else begin
            state_reg      <= state_next;
            ring_reg       <= ring_next;
            pos_reg        <= pos_next;
            sum_reg        <= sum_next;
            last_time_reg  <= last_time_next;
            last_width_reg <= last_width_next;
            near_count_reg <= near_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg   <= prod_next;
        in_win_reg <= in_win_next;
        dist_reg   <= dist_next;
        mean_reg   <= mean_next;
        upd_reg    <= upd_next;
        dw_reg     <= dw_next;
        dt_reg     <= dt_next;
    end

endmodule

// File: hw/rtl/edf_back.sv
// Back end: computes the smoothed approach rate and holds the result beat.
module edf_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              job_valid,
    output logic                              job_ready,
    input  edf_pkg::edf_job_t                 job,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [edf_pkg::DIST_W-1:0]        out_distance_mm,
    output logic signed [edf_pkg::RATE_W-1:0] out_approach_rate,
    output logic                              out_emergency
);
    import edf_pkg::*;

    localparam logic signed [SMOOTH_W-1:0] RATE_HI = SMOOTH_W'(32767);
    localparam logic signed [SMOOTH_W-1:0] RATE_LO = SMOOTH_W'(-32768);

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL,
        B_RAW_GO,
        B_RAW,
        B_SUM,
        B_AVG_HI,
        B_AVG_LO,
        B_LOAD
    } state_t;

    state_t                     state_reg, state_next;
    logic signed [SMOOTH_W-1:0] smoothed_reg, smoothed_next;
    logic                       out_valid_reg, out_valid_next;
    logic [DIST_W-1:0]          out_dist_reg, out_dist_next;
    logic signed [RATE_W-1:0]   out_rate_reg, out_rate_next;
    logic                       out_emerg_reg, out_emerg_next;

    edf_job_t                   job_reg, job_next;
    logic [DVD_W-1:0]           dvd_reg, dvd_next;
    logic                       neg_reg, neg_next;
    logic signed [SMOOTH_W-1:0] raw_reg, raw_next;
    logic [AVG_DIG_W-1:0]       avg_hi_reg, avg_hi_next;
    logic [AVG_REM_W-1:0]       avg_rem_reg, avg_rem_next;

    logic [DW_W-1:0]            dw_neg;
    logic [ECHO_W-1:0]          dw_mag;
    logic [PROD_W-1:0]          prod;
    logic signed [SUM4_W-1:0]   sum4;
    logic [SUM4_W-1:0]          sum4_neg;
    logic                       div_start;
    logic                       div_done;
    logic [DVD_W-1:0]           div_quot;
    logic signed [SMOOTH_W-1:0] quot_s;
    logic signed [SMOOTH_W-1:0] quot_signed;
    logic [AVG_V_W-1:0]         avg_v;
    logic [AVG_PROD_W-1:0]      avg_prod;
    logic [AVG_DIG_W-1:0]       avg_q;
    logic [AVG_V_W-1:0]         avg_back;
    logic [AVG_V_W-1:0]         avg_rem_full;
    logic [DVD_W-1:0]           avg_quot;
    logic signed [SMOOTH_W-1:0] avg_s;
    logic signed [SMOOTH_W-1:0] avg_signed;
    logic signed [RATE_W-1:0]   rate_sat;

    assign dw_neg   = -job_reg.dw;
    assign dw_mag   = job_reg.dw[DW_W-1] ? dw_neg[ECHO_W-1:0] : job_reg.dw[ECHO_W-1:0];
    assign prod     = PROD_W'(dw_mag) * PROD_W'(USEC_SCALE);
    // Four times the old rate plus the new raw rate, both sign-extended.
    assign sum4     = $signed({smoothed_reg[SMOOTH_W-1], smoothed_reg, 2'b00})
                      + $signed({{(SUM4_W - SMOOTH_W){raw_reg[SMOOTH_W-1]}}, raw_reg});
    assign sum4_neg = -sum4;

    assign div_start = state_reg == B_RAW_GO;

    // Both divisions work on magnitudes, so the sign is put back to truncate toward zero.
    assign quot_s      = SMOOTH_W'(div_quot);
    assign quot_signed = neg_reg ? -quot_s : quot_s;

    // Divide by five one digit per cycle: the upper half first, then the remainder
    // on top of the lower half.
    assign avg_v        = (state_reg == B_AVG_HI) ? AVG_V_W'(dvd_reg[DVD_W-1:AVG_DIG_W])
                                                  : {avg_rem_reg, dvd_reg[AVG_DIG_W-1:0]};
    assign avg_prod     = AVG_PROD_W'(avg_v) * AVG_PROD_W'(AVG_MUL);
    assign avg_q        = avg_prod[AVG_SHIFT +: AVG_DIG_W];
    assign avg_back     = AVG_V_W'(avg_q) * AVG_V_W'(SMOOTH_DIV);
    assign avg_rem_full = avg_v - avg_back;
    assign avg_quot     = {avg_hi_reg, avg_q};
    assign avg_s        = SMOOTH_W'(avg_quot);
    assign avg_signed   = neg_reg ? -avg_s : avg_s;

    always_comb begin
        if (smoothed_reg > RATE_HI) begin
            rate_sat = RATE_W'(RATE_HI);
        end else if (smoothed_reg < RATE_LO) begin
            rate_sat = RATE_W'(RATE_LO);
        end else begin
            rate_sat = smoothed_reg[RATE_W-1:0];
        end
    end

    edf_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dvd_reg),
        .divisor  (job_reg.dt),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign job_ready         = state_reg == B_IDLE;
    assign out_valid         = out_valid_reg;
    assign out_distance_mm   = out_dist_reg;
    assign out_approach_rate = out_rate_reg;
    assign out_emergency     = out_emerg_reg;

    always_comb begin
        state_next     = state_reg;
        smoothed_next  = smoothed_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_dist_next  = out_dist_reg;
        out_rate_next  = out_rate_reg;
        out_emerg_next = out_emerg_reg;
        job_next       = job_reg;
        dvd_next       = dvd_reg;
        neg_next       = neg_reg;
        raw_next       = raw_reg;
        avg_hi_next    = avg_hi_reg;
        avg_rem_next   = avg_rem_reg;
        case (state_reg)
            B_IDLE: begin
                if (job_valid) begin
                    job_next   = job;
                    state_next = job.upd ? B_MUL : B_LOAD;
                end
            end
            B_MUL: begin
                dvd_next   = DVD_W'(prod);
                neg_next   = job_reg.dw[DW_W-1];
                state_next = B_RAW_GO;
            end
            B_RAW_GO: begin
                state_next = B_RAW;
            end
            B_RAW: begin
                if (div_done) begin
                    raw_next   = quot_signed;
                    state_next = B_SUM;
                end
            end
            B_SUM: begin
                neg_next   = sum4[SUM4_W-1];
                dvd_next   = sum4[SUM4_W-1] ? sum4_neg[DVD_W-1:0] : sum4[DVD_W-1:0];
                state_next = B_AVG_HI;
            end
            B_AVG_HI: begin
                avg_hi_next  = avg_q;
                avg_rem_next = avg_rem_full[AVG_REM_W-1:0];
                state_next   = B_AVG_LO;
            end
            B_AVG_LO: begin
                smoothed_next = avg_signed;
                state_next    = B_LOAD;
            end
            B_LOAD: begin
                if (!out_valid_reg || out_ready) begin
                    out_valid_next = 1'b1;
                    out_dist_next  = job_reg.mean;
                    out_rate_next  = rate_sat;
                    out_emerg_next = job_reg.emergency;
                    state_next     = B_IDLE;
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            smoothed_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            smoothed_reg  <= smoothed_next;
            out_valid_reg <= out_valid_next;
        end
        out_dist_reg  <= out_dist_next;
        out_rate_reg  <= out_rate_next;
        out_emerg_reg <= out_emerg_next;
    end

    always_ff @(posedge aclk) begin
        job_reg     <= job_next;
        dvd_reg     <= dvd_next;
        neg_reg     <= neg_next;
        raw_reg     <= raw_next;
        avg_hi_reg  <= avg_hi_next;
        avg_rem_reg <= avg_rem_next;
    end

endmodule

// File: hw/rtl/echo_distance_filter_core.sv
// Top level of the echo distance filter: configuration registers and stream ports.
// Each input beat is one echo measurement and yields exactly one result beat carrying
// the moving-average distance, the smoothed approach rate and the emergency flag. The
// front end takes a measurement through conversion multiply, ring update, mean multiply
// and hand-off, and places it in a queue of QUEUE_DEPTH entries, two by default. The
// back end passes a measurement that leaves the rate unchanged straight to the result;
// an update runs the 38-step serial divide of the raw rate by the elapsed time and then
// the two-digit divide by five of the 4:1 smoothing. Each end takes a new measurement
// only once it is through with the last one. Configuration is written through cfg_we,
// cfg_index and cfg_data; the user must write it only while idle, the block does not enforce it.
module echo_distance_filter_core #(
    parameter int AVG_DEPTH   = edf_pkg::AVG_DEPTH_DEF,
    parameter int QUEUE_DEPTH = edf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [edf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [edf_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [14:0] echo_us, [46:15] time_ms, [47] zero
    input  logic [edf_pkg::S_TDATA_W-1:0]     s_tdata,
    // [0] echo_valid
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [11:0] distance_mm, [27:12] approach_rate, [28] emergency, [31:29] zero
    output logic [edf_pkg::M_TDATA_W-1:0]     m_tdata
);
    import edf_pkg::*;

    edf_cfg_t                 cfg_reg, cfg_next;
    edf_job_t                 front_job, back_job;
    logic                     front_valid, front_ready;
    logic                     back_valid, back_ready;
    logic [DIST_W-1:0]        res_distance;
    logic signed [RATE_W-1:0] res_rate;
    logic                     res_emergency;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                CFG_ECHO_MIN:     cfg_next.echo_min_us       = cfg_data[ECHO_W-1:0];
                CFG_ECHO_MAX:     cfg_next.echo_max_us       = cfg_data[ECHO_W-1:0];
                CFG_NEAR_LIMIT:   cfg_next.near_limit_mm     = cfg_data[LIMIT_W-1:0];
                CFG_MIN_INTERVAL: cfg_next.min_interval_ms   = cfg_data[INTERVAL_W-1:0];
                CFG_NEAR_NEEDED:  cfg_next.near_count_needed = cfg_data[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    edf_front #(
        .AVG_DEPTH (AVG_DEPTH)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_echo_valid (s_tuser),
        .in_echo_us    (s_tdata[ECHO_W-1:0]),
        .in_time_ms    (s_tdata[ECHO_W +: TIME_W]),
        .job_valid     (front_valid),
        .job_ready     (front_ready),
        .job           (front_job)
    );

    edf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_job    (front_job),
        .out_valid (back_valid),
        .out_ready (back_ready),
        .out_job   (back_job)
    );

    edf_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .job_valid         (back_valid),
        .job_ready         (back_ready),
        .job               (back_job),
        .out_valid         (m_tvalid),
        .out_ready         (m_tready),
        .out_distance_mm   (res_distance),
        .out_approach_rate (res_rate),
        .out_emergency     (res_emergency)
    );

    assign m_tdata = {3'b000, res_emergency, res_rate, res_distance};

endmodule
